// ===== src/ist_pkg.sv =====
`timescale 1ns / 1ps

package ist_pkg;

	localparam int VALUE_W = 32;
	localparam int FUNC_W  = 2;
	localparam int COUNT_W = 5;

	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic signed [VALUE_W-1:0] value;
	} cmd_word_t;

	typedef struct packed {
		logic               ok;
		logic               full_refused;
		logic [COUNT_W-1:0] count;
	} result_word_t;

	// per-cycle update control shared by every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

// ===== src/ist_cell.sv =====
`timescale 1ns / 1ps

module ist_cell #(
	parameter int IDX    = 0,
	parameter int IDX_W  = 4,
	parameter int CNT_W  = 5
) (
	input  logic                        clk,
	input  logic [ist_pkg::VALUE_W-1:0] cmp_value,
	input  logic [ist_pkg::VALUE_W-1:0] wr_value,
	input  logic [CNT_W-1:0]            count,
	input  logic [IDX_W-1:0]            pos,
	input  ist_pkg::cell_ctrl_t         ctrl,
	input  logic [ist_pkg::VALUE_W-1:0] nxt_data,
	output logic [ist_pkg::VALUE_W-1:0] data,
	output logic                        hit
);

	logic [ist_pkg::VALUE_W-1:0] data_q;
	logic                        live;

	assign live = CNT_W'(IDX) < count;
	assign hit  = live && (data_q == cmp_value);
	assign data = data_q;

	// remove pulls the neighbor's word down from the hit slot upward
	always_ff @(posedge clk) begin
		if (ctrl.rem && (IDX_W'(IDX) >= pos)) begin
			data_q <= nxt_data;
		end else if (ctrl.ins && (CNT_W'(IDX) == count)) begin
			data_q <= wr_value;
		end
	end

endmodule

// ===== src/ist_enc.sv =====
`timescale 1ns / 1ps

module ist_enc #(
	parameter int N     = 16,
	parameter int IDX_W = 4
) (
	input  logic [N-1:0]     hits,
	output logic [IDX_W-1:0] pos,
	output logic             any
);

	// entries are distinct, so at most one hit bit is set
	always_comb begin
		pos = '0;
		for (int i = 0; i < N; i++) begin
			if (hits[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end

	assign any = |hits;

endmodule

// ===== src/integer_set_table.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Word
// cmd      in         start high, busy low func, value
// result   out        done, one cycle      ok, full_refused, count
//
// For each word, the accept edge latches the parallel compare of
// every cell against the value, the next edge updates the cell row (append or
// shift-down) and registers the result, so done is high in the cycle after busy.
// busy is high for a single cycle, and no new word is taken while it is high.
// arst_n clears the fill count and control; stored words need no reset.
// The receiver cannot stall: result is valid only while done is high.
module integer_set_table #(
	parameter int CAPACITY = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ist_pkg::cmd_word_t    cmd,
	output logic                  done,
	output ist_pkg::result_word_t result
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            count_q;
	ist_pkg::result_word_t       result_q;
	logic [ist_pkg::FUNC_W-1:0]  func_s1;
	logic [ist_pkg::VALUE_W-1:0] value_s1;
	logic [CAPACITY-1:0]         hit_s1;

	logic [CAPACITY-1:0]         hit_w;
	logic [ist_pkg::VALUE_W-1:0] data_w [CAPACITY];
	logic [IDX_W-1:0]            pos;
	logic                        hit_any;
	logic                        full;
	logic                        accept;
	ist_pkg::cell_ctrl_t         ctrl;
	logic                        ok_c;
	logic                        refused_c;
	logic [CNT_W-1:0]            count_nxt;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [ist_pkg::VALUE_W-1:0] nxt;
			if (g + 1 < CAPACITY) begin : g_mid
				assign nxt = data_w[g+1];
			end else begin : g_end
				assign nxt = data_w[g];
			end
			ist_cell #(
				.IDX   (g),
				.IDX_W (IDX_W),
				.CNT_W (CNT_W)
			) u_cell (
				.clk       (clk),
				.cmp_value (cmd.value),
				.wr_value  (value_s1),
				.count     (count_q),
				.pos       (pos),
				.ctrl      (ctrl),
				.nxt_data  (nxt),
				.data      (data_w[g]),
				.hit       (hit_w[g])
			);
		end
	endgenerate

	ist_enc #(
		.N     (CAPACITY),
		.IDX_W (IDX_W)
	) u_enc (
		.hits (hit_s1),
		.pos  (pos),
		.any  (hit_any)
	);

	assign full = count_q == CNT_W'(CAPACITY);

	always_comb begin
		ctrl      = '0;
		ok_c      = 1'b0;
		refused_c = 1'b0;
		count_nxt = count_q;
		case (func_s1)
			ist_pkg::FUNC_LOOKUP: begin
				ok_c = hit_any;
			end
			ist_pkg::FUNC_INSERT: begin
				if (!hit_any) begin
					if (full) begin
						refused_c = 1'b1;
					end else begin
						ctrl.ins  = busy_q;
						ok_c      = 1'b1;
						count_nxt = count_q + CNT_W'(1);
					end
				end
			end
			ist_pkg::FUNC_REMOVE: begin
				if (hit_any) begin
					ctrl.rem  = busy_q;
					ok_c      = 1'b1;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= cmd.func;
			value_s1 <= cmd.value;
			hit_s1   <= hit_w;
		end
		if (busy_q) begin
			result_q.ok           <= ok_c;
			result_q.full_refused <= refused_c;
			result_q.count        <= ist_pkg::COUNT_W'(count_nxt);
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int TABLE_DEPTH = 16;
	localparam int RANDOM_WORDS = 1620;
	localparam int POOL_SIZE = 24;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [ist_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	// Tracks the set contents and the results still owed by the block.
	class set_scoreboard;
		logic [ist_pkg::VALUE_W-1:0] stored[TABLE_DEPTH];
		int unsigned fill;
		ist_pkg::result_word_t pending_results[$];
		int unsigned errors;
		int unsigned words;
		int unsigned checked;
		int unsigned added;
		int unsigned deleted;
		int unsigned hits;
		int unsigned refusals;

		function new();
			fill = 0;
			errors = 0;
			words = 0;
			checked = 0;
			added = 0;
			deleted = 0;
			hits = 0;
			refusals = 0;
		endfunction

		function ist_pkg::result_word_t apply_cmd(ist_pkg::cmd_word_t c);
			ist_pkg::result_word_t r;
			int pos;
			r = '0;
			pos = -1;
			for (int i = 0; i < fill; i++) begin
				if (pos < 0 && stored[i] == c.value)
					pos = i;
			end
			case (c.func)
			ist_pkg::FUNC_LOOKUP: begin
				r.ok = (pos >= 0);
			end
			ist_pkg::FUNC_INSERT: begin
				if (pos < 0) begin
					if (fill >= TABLE_DEPTH) begin
						r.full_refused = 1'b1;
					end else begin
						stored[fill] = c.value;
						fill++;
						r.ok = 1'b1;
					end
				end
			end
			ist_pkg::FUNC_REMOVE: begin
				if (pos >= 0) begin
					// close the gap so the table stays packed
					for (int i = pos; i + 1 < fill; i++)
						stored[i] = stored[i + 1];
					fill--;
					r.ok = 1'b1;
				end
			end
			default: begin
			end
			endcase
			r.count = ist_pkg::COUNT_W'(fill);
			return r;
		endfunction

		function void note_cmd(ist_pkg::cmd_word_t c);
			ist_pkg::result_word_t r;
			r = apply_cmd(c);
			words++;
			if (r.ok && c.func == ist_pkg::FUNC_INSERT) added++;
			if (r.ok && c.func == ist_pkg::FUNC_REMOVE) deleted++;
			if (r.ok && c.func == ist_pkg::FUNC_LOOKUP) hits++;
			if (r.full_refused) refusals++;
			pending_results.push_back(r);
		endfunction

		function void check_result(ist_pkg::result_word_t r);
			ist_pkg::result_word_t e;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result word with none pending: ok %0b full_refused %0b count %0d",
					$time, r.ok, r.full_refused, r.count);
				return;
			end
			e = pending_results.pop_front();
			checked++;
			if (r.ok !== e.ok) begin
				errors++;
				$display("%0t: ok expected %0b actual %0b", $time, e.ok, r.ok);
			end
			if (r.full_refused !== e.full_refused) begin
				errors++;
				$display("%0t: full_refused expected %0b actual %0b",
					$time, e.full_refused, r.full_refused);
			end
			if (r.count !== e.count) begin
				errors++;
				$display("%0t: count expected %0d actual %0d", $time, e.count, r.count);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	ist_pkg::cmd_word_t    cmd;
	logic                  done;
	ist_pkg::result_word_t result;

	set_scoreboard sb = new();
	int unsigned cycles = 0;
	bit steady;

	integer_set_table #(
		.CAPACITY(TABLE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// check before noting: a result and a new word can share an edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_cmd(cmd);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL integer_set_table");
			$finish;
		end
	end

	function automatic int draw_gap();
		if (steady)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	// start stays high after accept until the next falling edge
	task automatic send_word(input logic [ist_pkg::FUNC_W-1:0] f,
		input logic [ist_pkg::VALUE_W-1:0] v);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= '{func: f, value: v};
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		send_word(ist_pkg::FUNC_LOOKUP, 32'd0);
		send_word(ist_pkg::FUNC_REMOVE, 32'd5);
		send_word(FUNC_UNUSED, 32'd7);
		send_word(ist_pkg::FUNC_INSERT, 32'h8000_0000);
		send_word(ist_pkg::FUNC_INSERT, 32'h7fff_ffff);
		send_word(ist_pkg::FUNC_INSERT, 32'h0000_0000);
		send_word(ist_pkg::FUNC_INSERT, 32'hffff_ffff);
		send_word(ist_pkg::FUNC_INSERT, 32'h7fff_ffff);
		send_word(ist_pkg::FUNC_LOOKUP, 32'h8000_0000);
		send_word(ist_pkg::FUNC_LOOKUP, 32'h0000_0001);
		send_word(ist_pkg::FUNC_REMOVE, 32'h7fff_ffff);
		send_word(ist_pkg::FUNC_LOOKUP, 32'hffff_ffff);
		// three stored now; fill the rest of the table
		for (int i = 1; i <= TABLE_DEPTH - 3; i++)
			send_word(ist_pkg::FUNC_INSERT, 32'h0101_0101 * i);
		send_word(ist_pkg::FUNC_INSERT, 32'h1234_5678);
		send_word(ist_pkg::FUNC_INSERT, 32'h0000_0000);
		send_word(ist_pkg::FUNC_LOOKUP, 32'h0d0d_0d0d);
		send_word(FUNC_UNUSED, 32'hffff_ffff);
		send_word(ist_pkg::FUNC_REMOVE, 32'h8000_0000);
		send_word(ist_pkg::FUNC_REMOVE, 32'h0d0d_0d0d);
	endtask

	task automatic run_random();
		logic [ist_pkg::VALUE_W-1:0] pool[POOL_SIZE];
		logic [ist_pkg::FUNC_W-1:0] f;
		logic [ist_pkg::VALUE_W-1:0] v;
		int weight_ins;
		int roll;
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7fff_ffff;
		pool[2] = 32'h0000_0000;
		pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++)
			pool[i] = $urandom;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 100 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if (n % 400 == 200)
				wait_drained();
			// alternate fill-heavy and drain-heavy stretches
			weight_ins = ((n / 150) % 2 == 1) ? 20 : 55;
			roll = $urandom_range(0, 99);
			if (roll < 4)
				f = FUNC_UNUSED;
			else if (roll < 4 + weight_ins)
				f = ist_pkg::FUNC_INSERT;
			else if (roll < 78)
				f = ist_pkg::FUNC_REMOVE;
			else
				f = ist_pkg::FUNC_LOOKUP;
			if ($urandom_range(0, 3) == 0)
				v = $urandom;
			else
				v = pool[$urandom_range(0, POOL_SIZE - 1)];
			send_word(f, v);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		steady = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		wait_drained();
		run_random();
		wait_drained();
		repeat (4) @(posedge clk);
		$display("Ran %0d words: %0d values added, %0d deleted, %0d lookup hits,",
			sb.words, sb.added, sb.deleted, sb.hits);
		$display("%0d inserts turned away by a full table; %0d results checked, %0d mismatches.",
			sb.refusals, sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("PASS integer_set_table");
		end else begin
			$display("FAIL integer_set_table");
		end
		$finish;
	end

endmodule
